// ----- src/cpu8_alu_with_flags_defines.svh -----
// Assertion macros used by the ALU top level.
`ifndef CPU8_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU8_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define CPU8_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("cpu8 alu: same-cycle check failed");
// Next-cycle implication, disabled while reset is low.
`define CPU8_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("cpu8 alu: next-cycle check failed");
`else
`define CPU8_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define CPU8_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- src/cpu8alu_pkg.sv -----
// Operation codes, constants and shared types of the ALU.
package cpu8alu_pkg;

  localparam int KIND_W = 6;

  localparam logic [KIND_W-1:0] K_ADD    = 6'd0;
  localparam logic [KIND_W-1:0] K_ADC    = 6'd1;
  localparam logic [KIND_W-1:0] K_SUB    = 6'd2;
  localparam logic [KIND_W-1:0] K_SBC    = 6'd3;
  localparam logic [KIND_W-1:0] K_AND    = 6'd4;
  localparam logic [KIND_W-1:0] K_XOR    = 6'd5;
  localparam logic [KIND_W-1:0] K_OR     = 6'd6;
  localparam logic [KIND_W-1:0] K_CP     = 6'd7;
  localparam logic [KIND_W-1:0] K_INC8   = 6'd8;
  localparam logic [KIND_W-1:0] K_DEC8   = 6'd9;
  localparam logic [KIND_W-1:0] K_RLCA   = 6'd10;
  localparam logic [KIND_W-1:0] K_RRCA   = 6'd11;
  localparam logic [KIND_W-1:0] K_RLA    = 6'd12;
  localparam logic [KIND_W-1:0] K_RRA    = 6'd13;
  localparam logic [KIND_W-1:0] K_DAA    = 6'd14;
  localparam logic [KIND_W-1:0] K_CPL    = 6'd15;
  localparam logic [KIND_W-1:0] K_SCF    = 6'd16;
  localparam logic [KIND_W-1:0] K_CCF    = 6'd17;
  localparam logic [KIND_W-1:0] K_RLC    = 6'd18;
  localparam logic [KIND_W-1:0] K_RRC    = 6'd19;
  localparam logic [KIND_W-1:0] K_RL     = 6'd20;
  localparam logic [KIND_W-1:0] K_RR     = 6'd21;
  localparam logic [KIND_W-1:0] K_SLA    = 6'd22;
  localparam logic [KIND_W-1:0] K_SRA    = 6'd23;
  localparam logic [KIND_W-1:0] K_SWAP   = 6'd24;
  localparam logic [KIND_W-1:0] K_SRL    = 6'd25;
  localparam logic [KIND_W-1:0] K_BIT    = 6'd26;
  localparam logic [KIND_W-1:0] K_RES    = 6'd27;
  localparam logic [KIND_W-1:0] K_SET    = 6'd28;
  localparam logic [KIND_W-1:0] K_ADD16  = 6'd29;
  localparam logic [KIND_W-1:0] K_ADDSP  = 6'd30;
  localparam logic [KIND_W-1:0] K_INC16  = 6'd31;
  localparam logic [KIND_W-1:0] K_DEC16  = 6'd32;
  localparam logic [KIND_W-1:0] K_LDFLAG = 6'd33;

  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [3:0] DAA_DIGIT = 4'd9;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [15:0] result;
    logic        write_back;
    flags_t      flags;
  } alu_out_t;

endpackage

// ----- src/cpu8alu_core.sv -----
// Combinational datapath: one operation, result, write-back mark and new flags.
module cpu8alu_core (
  input  logic [cpu8alu_pkg::KIND_W-1:0] kind,
  input  logic [15:0]                    operand_a,
  input  logic [15:0]                    operand_b,
  input  logic [2:0]                     bit_index,
  input  cpu8alu_pkg::flags_t            flags_in,
  output cpu8alu_pkg::alu_out_t          alu_out
);
  import cpu8alu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        t_add;
  logic        t_sub;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  dif9;
  logic [4:0]  dif5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  daa_r;
  logic        daa_c;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_off;
  logic [7:0]  bit_mask;
  logic [7:0]  r8;
  flags_t      f;

  assign a        = operand_a[7:0];
  assign b        = operand_b[7:0];
  assign cin      = flags_in.c;
  assign t_add    = (kind == K_ADC) ? cin : 1'b0;
  assign t_sub    = (kind == K_SBC) ? cin : 1'b0;
  assign sum9     = {1'b0, a} + {1'b0, b} + {8'b0, t_add};
  assign sum5     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t_add};
  assign dif9     = {1'b0, a} - {1'b0, b} - {8'b0, t_sub};
  assign dif5     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t_sub};
  assign inc8     = a + 8'd1;
  assign dec8     = a - 8'd1;
  assign sum17    = {1'b0, operand_a} + {1'b0, operand_b};
  assign sum13    = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
  assign sp_off   = {{8{b[7]}}, b};
  assign bit_mask = 8'd1 << bit_index;

  // Decimal adjust after add or subtract.
  always_comb begin
    daa_r = a;
    daa_c = cin;
    if (!flags_in.n) begin
      if (cin || (a > DAA_LIMIT)) begin
        daa_r = daa_r + DAA_HI;
        daa_c = 1'b1;
      end
      if (flags_in.h || (a[3:0] > DAA_DIGIT)) begin
        daa_r = daa_r + DAA_LO;
      end
    end else begin
      if (cin) begin
        daa_r = daa_r - DAA_HI;
      end
      if (flags_in.h) begin
        daa_r = daa_r - DAA_LO;
      end
    end
  end

  always_comb begin
    r8                 = 8'd0;
    f                  = flags_in;
    alu_out.result     = 16'd0;
    alu_out.write_back = 1'b1;
    case (kind)
      K_ADD, K_ADC: begin
        r8 = sum9[7:0];
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
      end
      K_SUB, K_SBC, K_CP: begin
        r8 = dif9[7:0];
        f  = '{z: (r8 == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
        if (kind == K_CP) begin
          r8                 = 8'd0;
          alu_out.write_back = 1'b0;
        end
      end
      K_AND: begin
        r8 = a & b;
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      K_XOR: begin
        r8 = a ^ b;
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      K_OR: begin
        r8 = a | b;
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      K_INC8: begin
        r8 = inc8;
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: (r8[3:0] == 4'h0), c: cin};
      end
      K_DEC8: begin
        r8 = dec8;
        f  = '{z: (r8 == 8'd0), n: 1'b1, h: (r8[3:0] == 4'hF), c: cin};
      end
      K_RLCA, K_RLC: begin
        r8 = {a[6:0], a[7]};
        f  = '{z: (kind == K_RLC) && (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      K_RRCA, K_RRC: begin
        r8 = {a[0], a[7:1]};
        f  = '{z: (kind == K_RRC) && (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      K_RLA, K_RL: begin
        r8 = {a[6:0], cin};
        f  = '{z: (kind == K_RL) && (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      K_RRA, K_RR: begin
        r8 = {cin, a[7:1]};
        f  = '{z: (kind == K_RR) && (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      K_DAA: begin
        r8 = daa_r;
        f  = '{z: (r8 == 8'd0), n: flags_in.n, h: 1'b0, c: daa_c};
      end
      K_CPL: begin
        r8 = ~a;
        f  = '{z: flags_in.z, n: 1'b1, h: 1'b1, c: cin};
      end
      K_SCF: begin
        alu_out.write_back = 1'b0;
        f = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      K_CCF: begin
        alu_out.write_back = 1'b0;
        f = '{z: flags_in.z, n: 1'b0, h: 1'b0, c: ~cin};
      end
      K_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      K_SRA: begin
        r8 = {a[7], a[7:1]};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      K_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      K_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = '{z: (r8 == 8'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      K_BIT: begin
        alu_out.write_back = 1'b0;
        f = '{z: ~a[bit_index], n: 1'b0, h: 1'b1, c: cin};
      end
      K_RES: begin
        r8 = a & ~bit_mask;
      end
      K_SET: begin
        r8 = a | bit_mask;
      end
      default: begin
      end
    endcase

    alu_out.result = {8'd0, r8};

    // Wide operations drive the full result word.
    case (kind)
      K_ADD16: begin
        alu_out.result = sum17[15:0];
        f = '{z: flags_in.z, n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      K_ADDSP: begin
        alu_out.result = operand_a + sp_off;
        f = '{z: 1'b0, n: 1'b0, h: sum5[4], c: sum9[8]};
      end
      K_INC16: begin
        alu_out.result = operand_a + 16'd1;
      end
      K_DEC16: begin
        alu_out.result = operand_a - 16'd1;
      end
      K_LDFLAG: begin
        alu_out.result = {operand_a[15:4], 4'h0};
        f = operand_a[7:4];
      end
      default: begin
        if (kind > K_LDFLAG) begin
          alu_out.write_back = 1'b0;
        end
      end
    endcase

    alu_out.flags = f;
  end

endmodule

// ----- src/cpu8_alu_with_flags.sv -----
// Top level of the 8-bit CPU ALU: input stage, result stage and flag register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in_     | in        | in_valid / in_ready    | kind, operand_a, operand_b, bit_index
//   out_    | out       | out_valid / out_ready  | result, write_back, four flags
//
// One item per cycle sustained while the output is not stalled; a result passes the
// input register, then the result register, and turns valid once it is in the latter.
// The Z/N/H/C register updates when an item moves into the result register, so
// the next item in the input register already sees its flags.
// Synchronous active-low reset clears both stage valids and the flags.
// A stalled result holds; the input stage keeps taking items until it is full.
module cpu8_alu_with_flags (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpu8alu_pkg::KIND_W-1:0] in_kind,
  input  logic [15:0]                    in_operand_a,
  input  logic [15:0]                    in_operand_b,
  input  logic [2:0]                     in_bit_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [15:0]                    out_result,
  output logic                           out_write_back,
  output logic                           out_flag_zero,
  output logic                           out_flag_subtract,
  output logic                           out_flag_half_carry,
  output logic                           out_flag_carry
);
  import cpu8alu_pkg::*;

  `include "cpu8_alu_with_flags_defines.svh"

  // Input stage.
  logic              s1_v_r;
  logic              s1_v_nxt;
  logic [KIND_W-1:0] s1_kind_r;
  logic [15:0]       s1_a_r;
  logic [15:0]       s1_b_r;
  logic [2:0]        s1_bi_r;

  // Result stage and flag register.
  logic              out_v_r;
  logic              out_v_nxt;
  logic [15:0]       out_result_r;
  logic              out_wb_r;
  flags_t            flag_r;

  logic              in_xfer;
  logic              s2_load;
  alu_out_t          alu_out;

  // Advance into the result stage when it is empty or being drained.
  assign s2_load  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s2_load;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer) begin
      s1_v_nxt = 1'b1;
    end else if (s2_load) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s2_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  cpu8alu_core u_core (
    .kind      (s1_kind_r),
    .operand_a (s1_a_r),
    .operand_b (s1_b_r),
    .bit_index (s1_bi_r),
    .flags_in  (flag_r),
    .alu_out   (alu_out)
  );

  // Control state and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      flag_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s2_load) begin
        flag_r <= alu_out.flags;
      end
    end
  end

  // Payload: capture on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= in_kind;
      s1_a_r    <= in_operand_a;
      s1_b_r    <= in_operand_b;
      s1_bi_r   <= in_bit_index;
    end
    if (s2_load) begin
      out_result_r <= alu_out.result;
      out_wb_r     <= alu_out.write_back;
    end
  end

  // The flag register doubles as the flag part of the result register.
  assign out_valid           = out_v_r;
  assign out_result          = out_result_r;
  assign out_write_back      = out_wb_r;
  assign out_flag_zero       = flag_r.z;
  assign out_flag_subtract   = flag_r.n;
  assign out_flag_half_carry = flag_r.h;
  assign out_flag_carry      = flag_r.c;

  // An item moved forward always shows up as a valid result.
  `CPU8_ASSERT_NEXT(a_load_gives_result, clk, rst_n, s2_load, out_v_r)
  // A held input item stays put with its operation.
  `CPU8_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_v_r && !s2_load, s1_v_r && $stable(s1_kind_r))
  // Full pipe with a stalled result takes no new input.
  `CPU8_ASSERT_NOW(a_full_blocks, clk, rst_n, s1_v_r && out_v_r && !out_ready, !in_ready)

endmodule

// ----- sim/cpu8_alu_with_flags_tb.sv -----
// Self-checking testbench for the 8-bit CPU ALU with its Z/N/H/C flag register.

class alu_outcome_tracker;

  typedef struct {
    cpu8alu_pkg::alu_out_t      want;
    logic [cpu8alu_pkg::KIND_W-1:0] kind;
    int unsigned                idx;
  } pending_t;

  cpu8alu_pkg::flags_t flags_now;
  pending_t            pending_outcomes[$];
  int unsigned         n_noted;
  int unsigned         n_checked;
  int unsigned         errors;

  function new();
    flags_now = '0;
    n_noted   = 0;
    n_checked = 0;
    errors    = 0;
  endfunction

  function int unsigned pending();
    return pending_outcomes.size();
  endfunction

  // Compute the outcome of one operation and advance the flag register.
  function cpu8alu_pkg::alu_out_t compute_outcome(logic [cpu8alu_pkg::KIND_W-1:0] kind,
                                                  logic [15:0] a16, logic [15:0] b16,
                                                  logic [2:0] bi);
    cpu8alu_pkg::alu_out_t o;
    cpu8alu_pkg::flags_t   f;
    logic [7:0]  a, b, r8;
    logic [15:0] r16;
    logic        wide, wb, cin, t, c;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    a    = a16[7:0];
    b    = b16[7:0];
    f    = flags_now;
    cin  = f.c;
    r8   = 8'h00;
    r16  = 16'h0000;
    wide = 1'b0;
    wb   = 1'b1;
    case (kind)
      cpu8alu_pkg::K_ADD, cpu8alu_pkg::K_ADC: begin
        t   = (kind == cpu8alu_pkg::K_ADC) ? cin : 1'b0;
        s9  = {1'b0, a} + {1'b0, b} + {8'h00, t};
        s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
        r8  = s9[7:0];
        f.z = (r8 == 8'h00);
        f.n = 1'b0;
        f.h = s5[4];
        f.c = s9[8];
      end
      cpu8alu_pkg::K_SUB, cpu8alu_pkg::K_SBC, cpu8alu_pkg::K_CP: begin
        t   = (kind == cpu8alu_pkg::K_SBC) ? cin : 1'b0;
        s9  = {1'b0, a} - {1'b0, b} - {8'h00, t};
        s5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
        r8  = s9[7:0];
        f.z = (r8 == 8'h00);
        f.n = 1'b1;
        f.h = s5[4];
        f.c = s9[8];
        // compare only sets flags
        if (kind == cpu8alu_pkg::K_CP) begin
          r8 = 8'h00;
          wb = 1'b0;
        end
      end
      cpu8alu_pkg::K_AND: begin
        r8 = a & b;
        f  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      cpu8alu_pkg::K_XOR: begin
        r8 = a ^ b;
        f  = {r8 == 8'h00, 3'b000};
      end
      cpu8alu_pkg::K_OR: begin
        r8 = a | b;
        f  = {r8 == 8'h00, 3'b000};
      end
      cpu8alu_pkg::K_INC8: begin
        r8  = a + 8'h01;
        f.z = (r8 == 8'h00);
        f.n = 1'b0;
        f.h = (r8[3:0] == 4'h0);
      end
      cpu8alu_pkg::K_DEC8: begin
        r8  = a - 8'h01;
        f.z = (r8 == 8'h00);
        f.n = 1'b1;
        f.h = (r8[3:0] == 4'hF);
      end
      cpu8alu_pkg::K_RLCA, cpu8alu_pkg::K_RLC: begin
        r8 = {a[6:0], a[7]};
        f  = {(kind == cpu8alu_pkg::K_RLC) && (r8 == 8'h00), 2'b00, a[7]};
      end
      cpu8alu_pkg::K_RRCA, cpu8alu_pkg::K_RRC: begin
        r8 = {a[0], a[7:1]};
        f  = {(kind == cpu8alu_pkg::K_RRC) && (r8 == 8'h00), 2'b00, a[0]};
      end
      cpu8alu_pkg::K_RLA, cpu8alu_pkg::K_RL: begin
        r8 = {a[6:0], cin};
        f  = {(kind == cpu8alu_pkg::K_RL) && (r8 == 8'h00), 2'b00, a[7]};
      end
      cpu8alu_pkg::K_RRA, cpu8alu_pkg::K_RR: begin
        r8 = {cin, a[7:1]};
        f  = {(kind == cpu8alu_pkg::K_RR) && (r8 == 8'h00), 2'b00, a[0]};
      end
      cpu8alu_pkg::K_DAA: begin
        c  = cin;
        r8 = a;
        if (!f.n) begin
          if (c || a > cpu8alu_pkg::DAA_LIMIT) begin
            r8 = r8 + cpu8alu_pkg::DAA_HI;
            c  = 1'b1;
          end
          if (f.h || a[3:0] > cpu8alu_pkg::DAA_DIGIT) r8 = r8 + cpu8alu_pkg::DAA_LO;
        end else begin
          if (c) r8 = r8 - cpu8alu_pkg::DAA_HI;
          if (f.h) r8 = r8 - cpu8alu_pkg::DAA_LO;
        end
        f = {r8 == 8'h00, f.n, 1'b0, c};
      end
      cpu8alu_pkg::K_CPL: begin
        r8  = ~a;
        f.n = 1'b1;
        f.h = 1'b1;
      end
      cpu8alu_pkg::K_SCF: begin
        wb = 1'b0;
        f  = {f.z, 3'b001};
      end
      cpu8alu_pkg::K_CCF: begin
        wb = 1'b0;
        f  = {f.z, 2'b00, ~cin};
      end
      cpu8alu_pkg::K_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = {r8 == 8'h00, 2'b00, a[7]};
      end
      cpu8alu_pkg::K_SRA: begin
        r8 = {a[7], a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      cpu8alu_pkg::K_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = {r8 == 8'h00, 3'b000};
      end
      cpu8alu_pkg::K_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      cpu8alu_pkg::K_BIT: begin
        wb = 1'b0;
        f  = {~a[bi], 1'b0, 1'b1, cin};
      end
      cpu8alu_pkg::K_RES: r8 = a & ~(8'h01 << bi);
      cpu8alu_pkg::K_SET: r8 = a | (8'h01 << bi);
      cpu8alu_pkg::K_ADD16: begin
        wide = 1'b1;
        s17  = {1'b0, a16} + {1'b0, b16};
        s13  = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        r16  = s17[15:0];
        f.n  = 1'b0;
        f.h  = s13[12];
        f.c  = s17[16];
      end
      cpu8alu_pkg::K_ADDSP: begin
        wide = 1'b1;
        r16  = a16 + {{8{b[7]}}, b};
        s5   = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        s9   = {1'b0, a} + {1'b0, b};
        f    = {2'b00, s5[4], s9[8]};
      end
      cpu8alu_pkg::K_INC16: begin
        wide = 1'b1;
        r16  = a16 + 16'h0001;
      end
      cpu8alu_pkg::K_DEC16: begin
        wide = 1'b1;
        r16  = a16 - 16'h0001;
      end
      cpu8alu_pkg::K_LDFLAG: begin
        wide = 1'b1;
        r16  = {a16[15:4], 4'h0};
        f    = cpu8alu_pkg::flags_t'(a16[7:4]);
      end
      default: wb = 1'b0;
    endcase
    flags_now    = f;
    o.result     = wide ? r16 : {8'h00, r8};
    o.write_back = wb;
    o.flags      = f;
    return o;
  endfunction

  function void note_operation(logic [cpu8alu_pkg::KIND_W-1:0] kind, logic [15:0] a16,
                               logic [15:0] b16, logic [2:0] bi);
    pending_t p;
    p.want = compute_outcome(kind, a16, b16, bi);
    p.kind = kind;
    p.idx  = n_noted;
    pending_outcomes.push_back(p);
    n_noted++;
  endfunction

  task report(string what);
    errors++;
    $display("[%0t] ALU MISMATCH: %s", $time, what);
  endtask

  task check_outcome(cpu8alu_pkg::alu_out_t got);
    pending_t p;
    n_checked++;
    if (pending_outcomes.size() == 0) begin
      report($sformatf("result %h wb %b flags %b with no operation outstanding",
                       got.result, got.write_back, got.flags));
      return;
    end
    p = pending_outcomes.pop_front();
    if (got !== p.want)
      report($sformatf("op #%0d kind %0d: got res %h wb %b znhc %b, want res %h wb %b znhc %b",
                       p.idx, p.kind, got.result, got.write_back, got.flags,
                       p.want.result, p.want.write_back, p.want.flags));
  endtask

endclass

module cpu8_alu_with_flags_tb;
  import cpu8alu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_OPS  = 750;
  localparam int          N_PHASES    = 4;
  localparam int          HOLD_CYCLES = 60;
  localparam int          DRAIN_WAIT  = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [KIND_W-1:0] K_UNUSED_MAX = {KIND_W{1'b1}};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [15:0]       in_operand_a = '0;
  logic [15:0]       in_operand_b = '0;
  logic [2:0]        in_bit_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       out_result;
  logic              out_write_back;
  logic              out_flag_zero;
  logic              out_flag_subtract;
  logic              out_flag_half_carry;
  logic              out_flag_carry;

  // Knobs of the current phase, in percent.
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  logic        hold_rcv      = 1'b0;

  int unsigned cycle_cnt   = 0;
  int unsigned n_ops       = 0;
  int unsigned n_ignored   = 0;
  int unsigned n_daa_seq   = 0;
  int unsigned input_stall = 0;
  bit          kind_seen[64];

  alu_outcome_tracker tracker = new();

  cpu8_alu_with_flags i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_operand_a        (in_operand_a),
    .in_operand_b        (in_operand_b),
    .in_bit_index        (in_bit_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result          (out_result),
    .out_write_back      (out_write_back),
    .out_flag_zero       (out_flag_zero),
    .out_flag_subtract   (out_flag_subtract),
    .out_flag_half_carry (out_flag_half_carry),
    .out_flag_carry      (out_flag_carry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, tracker.pending());
      $display("cpu8_alu_with_flags_tb NOT OK");
      $finish;
    end
  end

  // Sample both channels at the rising edge, before the block's registers move.
  // Check the result first: it can never belong to the transfer of this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_outcome('{result: out_result, write_back: out_write_back,
                                flags: '{z: out_flag_zero, n: out_flag_subtract,
                                         h: out_flag_half_carry, c: out_flag_carry}});
      if (in_valid && in_ready) begin
        tracker.note_operation(in_kind, in_operand_a, in_operand_b, in_bit_index);
        kind_seen[in_kind] = 1'b1;
      end
      if (in_valid && !in_ready) input_stall++;
    end
  end

  // Receiver: stall at random, or hold off completely while a pressure test runs.
  always @(negedge clk) begin
    if (hold_rcv) out_ready <= 1'b0;
    else          out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Offer one operation at a falling edge and hold it until its transfer.
  // Leave the task at the falling edge right after the transfer, valid still high.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [15:0] a,
                         input logic [15:0] b, input logic [2:0] bi);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid     <= 1'b0;
      in_kind      <= KIND_W'($urandom);
      in_operand_a <= 16'($urandom);
      in_operand_b <= 16'($urandom);
      in_bit_index <= 3'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_operand_a <= a;
    in_operand_b <= b;
    in_bit_index <= bi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'h0F0F;
      4:       return 16'h8080;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] bcd_byte();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  // One random step: mostly plain operations, some decimal-adjust sequences,
  // some flag loads that put the flag register into arbitrary states, some noise.
  task automatic send_random();
    logic [7:0]        x, y;
    logic [KIND_W-1:0] k;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // unused codes: the block ignores them, so they do not count
      send_op(KIND_W'($urandom_range(K_UNUSED_MAX, K_LDFLAG + 1)), 16'($urandom),
              16'($urandom), 3'($urandom));
      n_ignored++;
    end else if (pick < 22) begin
      // BCD add or subtract, then adjust the true accumulator
      x = bcd_byte();
      y = bcd_byte();
      if ($urandom_range(1)) begin
        send_op(K_ADD, {8'($urandom), x}, {8'($urandom), y}, 3'($urandom));
        send_op(K_DAA, {8'($urandom), x + y}, 16'($urandom), 3'($urandom));
      end else begin
        send_op(K_SUB, {8'($urandom), x}, {8'($urandom), y}, 3'($urandom));
        send_op(K_DAA, {8'($urandom), x - y}, 16'($urandom), 3'($urandom));
      end
      n_ops += 2;
      n_daa_seq++;
    end else if (pick < 30) begin
      send_op(K_LDFLAG, 16'($urandom), 16'($urandom), 3'($urandom));
      k = ($urandom_range(1)) ? K_DAA : KIND_W'($urandom_range(K_LDFLAG, K_ADD));
      send_op(k, pick_operand(), pick_operand(), 3'($urandom));
      n_ops += 2;
    end else begin
      send_op(KIND_W'($urandom_range(K_LDFLAG, K_ADD)), pick_operand(), pick_operand(),
              3'($urandom));
      n_ops++;
    end
  endtask

  task automatic run_directed();
    // carry and half carry out of both nibbles, zero result
    send_op(K_ADD,    16'hFFFF, 16'hFF01, 3'd0);
    send_op(K_ADC,    16'h000F, 16'h0000, 3'd0);
    send_op(K_SUB,    16'h0000, 16'h0001, 3'd0);
    send_op(K_SBC,    16'h0010, 16'h000F, 3'd0);
    send_op(K_AND,    16'hFFFF, 16'h0000, 3'd0);
    send_op(K_XOR,    16'h00AA, 16'hFFAA, 3'd0);
    send_op(K_OR,     16'h0000, 16'h0000, 3'd0);
    send_op(K_CP,     16'h0042, 16'h0042, 3'd0);
    send_op(K_INC8,   16'hFFFF, 16'h0000, 3'd0);
    send_op(K_DEC8,   16'h0010, 16'h0000, 3'd0);
    // accumulator rotates always clear Z, even on a zero result
    send_op(K_RLCA,   16'h0080, 16'h0000, 3'd0);
    send_op(K_RRCA,   16'h0000, 16'h0000, 3'd0);
    send_op(K_RLA,    16'h0080, 16'h0000, 3'd0);
    send_op(K_RRA,    16'h0000, 16'h0000, 3'd0);
    // decimal adjust after add with a high carry and after subtract with half borrow
    send_op(K_ADD,    16'h0099, 16'h0001, 3'd0);
    send_op(K_DAA,    16'h009A, 16'h0000, 3'd0);
    send_op(K_SUB,    16'h0010, 16'h0001, 3'd0);
    send_op(K_DAA,    16'h000F, 16'h0000, 3'd0);
    send_op(K_CPL,    16'hFF0F, 16'h0000, 3'd0);
    send_op(K_SCF,    16'hFFFF, 16'hFFFF, 3'd7);
    send_op(K_CCF,    16'hFFFF, 16'hFFFF, 3'd7);
    send_op(K_RLC,    16'hFF00, 16'h0000, 3'd0);
    send_op(K_RRC,    16'h0001, 16'h0000, 3'd0);
    send_op(K_RL,     16'h0080, 16'h0000, 3'd0);
    send_op(K_RR,     16'h0001, 16'h0000, 3'd0);
    send_op(K_SLA,    16'h0080, 16'h0000, 3'd0);
    send_op(K_SRA,    16'h0081, 16'h0000, 3'd0);
    send_op(K_SWAP,   16'h00F0, 16'h0000, 3'd0);
    send_op(K_SRL,    16'h0001, 16'h0000, 3'd0);
    send_op(K_BIT,    16'h007F, 16'h0000, 3'd7);
    send_op(K_BIT,    16'h00FF, 16'h0000, 3'd0);
    send_op(K_RES,    16'h00FF, 16'h0000, 3'd7);
    send_op(K_SET,    16'h0000, 16'h0000, 3'd0);
    // 16-bit add: Z stays, H from bit 11, C from bit 15
    send_op(K_ADD16,  16'h0FFF, 16'h0001, 3'd0);
    send_op(K_ADD16,  16'hFFFF, 16'h0001, 3'd0);
    // stack offset add with a negative offset: flags from the low byte
    send_op(K_ADDSP,  16'hFFF8, 16'h00FF, 3'd0);
    send_op(K_ADDSP,  16'h0000, 16'hFF80, 3'd0);
    send_op(K_INC16,  16'hFFFF, 16'h0000, 3'd0);
    send_op(K_DEC16,  16'h0000, 16'h0000, 3'd0);
    send_op(K_LDFLAG, 16'hFFFF, 16'h0000, 3'd0);
    // unused code keeps all flags set
    send_op(K_UNUSED_MAX, 16'hFFFF, 16'hFFFF, 3'd7);
    send_op(K_LDFLAG, 16'h0000, 16'h0000, 3'd0);
    n_ops += 41;
    n_ignored++;
  endtask

  initial begin
    int unsigned idle_tab[N_PHASES];
    int unsigned stall_tab[N_PHASES];
    int unsigned n_kinds;
    idle_tab  = '{0, 77, 0, 34};
    stall_tab = '{0, 0, 77, 34};
    n_kinds   = 0;

    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      snd_idle_pct  = idle_tab[ph];
      rcv_stall_pct = stall_tab[ph];
      if (ph == 0) begin
        // Block the receiver for a long stretch while the sender keeps pushing,
        // so both stages fill and in_ready drops.
        fork
          begin
            for (int i = 0; i < 40; i++) send_random();
          end
          begin
            @(posedge clk);
            hold_rcv = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rcv = 1'b0;
          end
        join
      end
      while (n_ops + n_ignored < (RANDOM_OPS * (ph + 1)) / N_PHASES) send_random();
    end
    in_valid <= 1'b0;

    // Drain, then linger to catch any stray result.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    foreach (kind_seen[k]) if (kind_seen[k] && k <= K_LDFLAG) n_kinds++;
    $display("covered %0d of 34 operations over %0d counted and %0d ignored transfers,",
             n_kinds, n_ops, n_ignored);
    $display("%0d decimal-adjust sequences, %0d input stall cycles, %0d results checked",
             n_daa_seq, input_stall, tracker.n_checked);
    if (tracker.errors == 0) begin
      $display("cpu8_alu_with_flags_tb OK");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("cpu8_alu_with_flags_tb NOT OK");
    end
    $finish;
  end

endmodule
